// File: design/rtuf_pkg.sv
// Shared types, constants and CRC step function for the RTU request framer.
// No dependencies; used by every module of the block.
package rtuf_pkg;

  localparam int FRAME_LEN  = 8;
  localparam int BYTE_IDX_W = $clog2(FRAME_LEN);

  // Byte slots of the frame, wire order
  localparam logic [BYTE_IDX_W-1:0] SLOT_SLAVE   = 3'd0;
  localparam logic [BYTE_IDX_W-1:0] SLOT_FUNC    = 3'd1;
  localparam logic [BYTE_IDX_W-1:0] SLOT_ADDR_HI = 3'd2;
  localparam logic [BYTE_IDX_W-1:0] SLOT_ADDR_LO = 3'd3;
  localparam logic [BYTE_IDX_W-1:0] SLOT_VAL_HI  = 3'd4;
  localparam logic [BYTE_IDX_W-1:0] SLOT_VAL_LO  = 3'd5;
  localparam logic [BYTE_IDX_W-1:0] SLOT_CRC_LO  = 3'd6;
  localparam logic [BYTE_IDX_W-1:0] SLOT_CRC_HI  = 3'd7;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  typedef struct packed {
    logic [7:0]  slave_id;
    logic [7:0]  function_code;
    logic [15:0] register_address;
    logic [15:0] register_value;
  } req_t;

  // One byte through the reflected CRC-16, bit at a time (eight narrow steps)
  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// File: design/rtuf_serializer.sv
// Frame serialiser: holds one request, walks its eight bytes out and folds
// each header byte into a running CRC. Depends on rtuf_pkg.
module rtuf_serializer
  import rtuf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  req_t       load_req,
  output logic       can_load,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_frame_byte,
  output logic       out_frame_last
);

  req_t                  req_r;
  logic                  busy_r,  busy_nxt;
  logic [BYTE_IDX_W-1:0] idx_r,   idx_nxt;
  logic [15:0]           crc_r,   crc_nxt;
  logic                  xfer;
  logic                  last_xfer;
  logic [7:0]            cur_byte;

  assign xfer      = busy_r && !out_stall;
  assign last_xfer = xfer && (idx_r == SLOT_CRC_HI);
  assign can_load  = !busy_r || last_xfer;

  always_comb begin
    case (idx_r)
      SLOT_SLAVE:   cur_byte = req_r.slave_id;
      SLOT_FUNC:    cur_byte = req_r.function_code;
      SLOT_ADDR_HI: cur_byte = req_r.register_address[15:8];
      SLOT_ADDR_LO: cur_byte = req_r.register_address[7:0];
      SLOT_VAL_HI:  cur_byte = req_r.register_value[15:8];
      SLOT_VAL_LO:  cur_byte = req_r.register_value[7:0];
      SLOT_CRC_LO:  cur_byte = crc_r[7:0];
      default:      cur_byte = crc_r[15:8];
    endcase
  end

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    crc_nxt  = crc_r;
    if (xfer) begin
      idx_nxt = idx_r + 1'b1;
      if (idx_r < SLOT_CRC_LO) crc_nxt = crc16_step(crc_r, cur_byte);
      if (last_xfer) busy_nxt = 1'b0;
    end
    if (load) begin
      busy_nxt = 1'b1;
      idx_nxt  = SLOT_SLAVE;
      crc_nxt  = CRC_INIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= SLOT_SLAVE;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    crc_r <= crc_nxt;
    if (load) req_r <= load_req;
  end

  assign out_valid      = busy_r;
  assign out_frame_byte = cur_byte;
  assign out_frame_last = (idx_r == SLOT_CRC_HI);

endmodule

// File: design/rtu_request_framer_crc16.sv
// Top level of the RTU request framer: input holding stage plus serialiser.
// Depends on rtuf_pkg and rtuf_serializer.
//
// Usage
//   Input channel (in_*): one request per transfer - slave address,
//   function code, 16-bit register address, 16-bit value or count.
//   Result channel (out_*): eight byte transfers per request, wire order:
//   slave, function, address hi/lo, value hi/lo, then the CRC-16 low byte
//   and high byte. out_frame_last marks the eighth byte.
//   Latency: the first byte of a request is shown the cycle after its
//   input transfer when the serialiser is free.
//   Throughput: one byte per cycle while out_stall is low; the output
//   channel is the bottleneck. The CRC is folded in byte by byte as
//   the header goes out, so it is ready exactly when its slot comes up.
//   A one-entry holding register takes the next request while the current
//   frame is still draining; in_stall rises only when that entry is full.
//   Receiver stall: out_stall freezes the byte counter and CRC, so the
//   shown byte holds until it is taken; nothing is dropped.
//   Reset (rst_n low, synchronous): empties the holding register and
//   idles the serialiser; out_valid and in_stall go low.
module rtu_request_framer_crc16
  import rtuf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_slave_id,
  input  logic [7:0]  in_function_code,
  input  logic [15:0] in_register_address,
  input  logic [15:0] in_register_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_frame_byte,
  output logic        out_frame_last
);

  req_t in_req;
  req_t hold_req_r;
  logic hold_valid_r, hold_valid_nxt;
  logic in_xfer;
  logic can_load;
  logic load;
  req_t load_req;

  assign in_req = '{slave_id:         in_slave_id,
                    function_code:    in_function_code,
                    register_address: in_register_address,
                    register_value:   in_register_value};

  // Held request always goes first; otherwise bypass straight from the port
  assign in_stall = hold_valid_r;
  assign in_xfer  = in_valid && !hold_valid_r;
  assign load     = can_load && (hold_valid_r || in_valid);
  assign load_req = hold_valid_r ? hold_req_r : in_req;

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    if (load && hold_valid_r) hold_valid_nxt = 1'b0;
    if (in_xfer && !can_load) hold_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && !can_load) hold_req_r <= in_req;
  end

  rtuf_serializer u_ser (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (load),
    .load_req       (load_req),
    .can_load       (can_load),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_frame_byte (out_frame_byte),
    .out_frame_last (out_frame_last)
  );

endmodule

// File: design/rtuf_checker.sv
// Port-level checker for the RTU request framer, bound to the top level.
// Depends on rtuf_pkg and rtu_request_framer_crc16.
module rtuf_checker
  import rtuf_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_frame_byte,
  input logic       out_frame_last
);

  logic [BYTE_IDX_W-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (out_valid && !out_stall) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  // Stalled byte holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_frame_byte) && $stable(out_frame_last))
    else $error("stalled output byte changed");

  // Every eighth byte transfer, and only that one, closes a frame
  a_frame_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_frame_last == (cnt_r == SLOT_CRC_HI)))
    else $error("frame_last out of step with byte count");

  // Input only backs up while a frame is draining
  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no frame in flight");

  // Last byte taken with a request waiting: next frame follows at once
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_frame_last && in_stall |=> out_valid && !out_frame_last)
    else $error("gap between back-to-back frames");

endmodule

bind rtu_request_framer_crc16 rtuf_checker u_rtuf_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_frame_byte (out_frame_byte),
  .out_frame_last (out_frame_last)
);
